FILE: rtl/mandelbrot_block_shader_macros.svh
// assertion helpers, compiled away for synthesis
`ifndef MANDELBROT_BLOCK_SHADER_MACROS_SVH
`define MANDELBROT_BLOCK_SHADER_MACROS_SVH
`ifndef SYNTHESIS
`define MBS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mbs assertion failed");
`define MBS_NEVER(lbl, cond) \
	`MBS_ASSERT(lbl, !(cond))
`else
`define MBS_ASSERT(lbl, prop)
`define MBS_NEVER(lbl, cond)
`endif
`endif

FILE: rtl/mbs_pkg.sv
`default_nettype none
package mbs_pkg;

	localparam int MAX_ITER_DEF   = 100;
	localparam int MAX_BLOCK_DEF  = 8;
	localparam int FRAC_BITS_DEF  = 56;
	localparam int COORD_BITS     = 12;
	localparam int EDGE_W         = 13;
	localparam int BSZ_W          = 4;
	localparam int NUM_W          = 21;

	// register indexes
	localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_PIXEL_SCALE  = 3'd2;
	localparam logic [2:0] CFG_FOCUS_REAL   = 3'd3;
	localparam logic [2:0] CFG_FOCUS_IMAG   = 3'd4;
	localparam logic [2:0] CFG_BLOCK_WIDTH  = 3'd5;
	localparam logic [2:0] CFG_BLOCK_HEIGHT = 3'd6;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         busy;
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [EDGE_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [7:0] quo;
	} div_rsp_t;

	// signed add clamped to the 64 bit range
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			sat_add = s[63:0];
	endfunction

	function automatic logic [63:0] mag(input logic [63:0] v);
		mag = v[63] ? (64'd0 - v) : v;
	endfunction

	// floor(k*255/50) = 5k + floor(k/10) for k up to 50
	function automatic logic [7:0] shade_of_k(input logic [5:0] k);
		logic [7:0] t;
		t = 8'(k >= 6'd10) + 8'(k >= 6'd20) + 8'(k >= 6'd30) + 8'(k >= 6'd40)
			+ 8'(k >= 6'd50);
		shade_of_k = 8'({2'b00, k} * 8'd5) + t;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/mbs_mul.sv
`default_nettype none
// 64x64 multiplier, one 32x32 partial product per cycle
module mbs_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mbs_pkg::mul_req_t req,
	output mbs_pkg::mul_rsp_t      rsp
);

	logic [63:0]  a_q, b_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q, pv_s1;
	logic [1:0]   sel_s1;
	logic [63:0]  pp_s1;
	logic [127:0] acc_q;
	logic [31:0]  ah, bh;
	logic [127:0] pp_ext;

	assign ah = cnt_q[0] ? a_q[63:32] : a_q[31:0];
	assign bh = cnt_q[1] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (sel_s1)
			2'd0: pp_ext = {64'd0, pp_s1};
			2'd3: pp_ext = {pp_s1, 64'd0};
			default: pp_ext = {32'd0, pp_s1, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q != 3'd4) begin
					pv_s1 <= 1'b1;
					cnt_q <= cnt_q + 3'd1;
				end
				if (pv_s1 && sel_s1 == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else begin
			pp_s1  <= ah * bh;
			sel_s1 <= cnt_q[1:0];
			if (pv_s1)
				acc_q <= acc_q + pp_ext;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule
`default_nettype wire

FILE: rtl/mbs_div.sv
`default_nettype none
// radix-2 divider, quotient saturated at 255
module mbs_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mbs_pkg::div_req_t req,
	output mbs_pkg::div_rsp_t      rsp
);

	logic [mbs_pkg::NUM_W-1:0]  rem_q, trial;
	logic [mbs_pkg::EDGE_W-1:0] den_q;
	logic [7:0]                 q_q;
	logic [2:0]                 cnt_q;
	logic                       busy_q, done_q;

	assign trial = {8'd0, den_q} << cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= 3'd7;
				if (req.num >= {req.den, 8'd0})
					done_q <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			q_q   <= (req.num >= {req.den, 8'd0}) ? 8'hff : 8'd0;
		end else if (busy_q && rem_q >= trial) begin
			rem_q <= rem_q - trial;
			q_q   <= q_q | (8'd1 << cnt_q);
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = q_q;

endmodule
`default_nettype wire

FILE: rtl/mandelbrot_block_shader.sv
// sequence: map the block centre, then up to MAX_ITER+1 escape iterations of three
// products each on the four-pass 32x32 multiplier, then for each emitted pixel two
// passes of the radix-2 divider plus output wait
// throughput: one block at a time, input ready again the cycle after the last pixel leaves
// reset: arst_n asynchronous active low, registers return to their reset values, no sweep
`default_nettype none
`include "mandelbrot_block_shader_macros.svh"
module mandelbrot_block_shader #(
	parameter int MAX_ITER  = mbs_pkg::MAX_ITER_DEF,
	parameter int MAX_BLOCK = mbs_pkg::MAX_BLOCK_DEF,
	parameter int FRAC_BITS = mbs_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write request
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	// block request
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// block_x[11:0], block_y[23:12], region_right[36:24], region_bottom[49:37], zero fill
	input  wire logic [55:0] s_axis_tdata,
	// pixel request
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// pixel_x[11:0], pixel_y[23:12], red[31:24], blue[39:32]
	output logic [39:0]      m_axis_tdata,
	output logic             m_axis_tlast
);

	localparam int SW = $clog2(MAX_ITER + 1);
	localparam logic [63:0] TWO  = 64'd2 << FRAC_BITS;
	localparam logic [64:0] FOUR = 65'd4 << FRAC_BITS;
	localparam int EW = mbs_pkg::EDGE_W;
	localparam int BW = mbs_pkg::BSZ_W;

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_MAPR, S_MAPI, S_ESC, S_SQR, S_SQI, S_CROSS,
		S_PIX, S_DIVR, S_DIVB, S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [EW-1:0] img_w_q, img_h_q;
	logic [62:0]   scale_q;
	logic [63:0]   foc_re_q, foc_im_q;
	logic [BW-1:0] blk_w_q, blk_h_q;

	// block registers
	logic [11:0]   bx_q, by_q;
	logic [EW-1:0] rr_q, rb_q;
	logic [BW-1:0] bw_q, bh_q, ncols_q, nrows_q, c_q, r_q;
	logic [13:0]   m_im_q;
	logic          dre_neg_q, dim_neg_q;

	// escape loop
	logic [63:0]   cr_q, ci_q, zr_q, zi_q, ar_q, ai_q, sr_q, si_q;
	logic [SW-1:0] step_q;
	logic [5:0]    k_q;
	logic [7:0]    shade_q;

	// pixel output
	logic [7:0]    red_q, blue_q;
	logic          last_q;

	mbs_pkg::mul_req_t mul_req;
	mbs_pkg::mul_rsp_t mul_rsp;
	mbs_pkg::div_req_t div_req;
	mbs_pkg::div_rsp_t div_rsp;

	mbs_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	mbs_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// clamp block size to 1..MAX_BLOCK
	function automatic logic [BW-1:0] clamp_bs(input logic [BW-1:0] v);
		if (v == '0)
			clamp_bs = BW'(1);
		else if (v > BW'(MAX_BLOCK))
			clamp_bs = BW'(MAX_BLOCK);
		else
			clamp_bs = v;
	endfunction

	// pixels of the block inside the region
	function automatic logic [BW-1:0] span(input logic [EW-1:0] edge_v,
			input logic [11:0] org, input logic [BW-1:0] bs);
		logic [EW-1:0] diff;
		diff = edge_v - {1'b0, org};
		if (edge_v <= {1'b0, org})
			span = '0;
		else if (diff > EW'(bs))
			span = bs;
		else
			span = diff[BW-1:0];
	endfunction

	// offset d = 2*centre - size, signed 15 bits
	function automatic logic [14:0] offs(input logic [11:0] org, input logic [BW-1:0] bs,
			input logic [EW-1:0] size);
		logic [EW-1:0] centre;
		centre = EW'(org) + EW'(bs >> 1);
		offs = {1'b0, centre, 1'b0} - {2'b00, size};
	endfunction

	// c from the scale product; an overflowing product saturates by sign
	function automatic logic [63:0] map_c(input logic [127:0] prod, input logic neg,
			input logic [63:0] foc);
		logic [63:0] half;
		if (prod[127:64] != '0)
			map_c = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else begin
			half = {1'b0, prod[63:1]};
			map_c = mbs_pkg::sat_add(foc, neg ? (64'd0 - half) : half);
		end
	endfunction

	logic [14:0]   d_re, d_im;
	logic [13:0]   m_re, m_im;
	logic [BW-1:0] bw_c, bh_c;
	logic [63:0]   ar_c, ai_c;
	logic [64:0]   mag2;
	logic [63:0]   sq_shf, cross_p;
	logic [EW-1:0] col, row, wd, hd;

	assign bw_c = clamp_bs(blk_w_q);
	assign bh_c = clamp_bs(blk_h_q);
	assign d_re = offs(bx_q, bw_q, img_w_q);
	assign d_im = offs(by_q, bh_q, img_h_q);
	assign m_re = d_re[14] ? 14'(15'd0 - d_re) : d_re[13:0];
	assign m_im = d_im[14] ? 14'(15'd0 - d_im) : d_im[13:0];
	assign ar_c = mbs_pkg::mag(zr_q);
	assign ai_c = mbs_pkg::mag(zi_q);
	assign sq_shf  = 64'(mul_rsp.prod >> FRAC_BITS);
	assign cross_p = 64'(mul_rsp.prod >> (FRAC_BITS - 1));
	assign mag2 = {1'b0, sr_q} + {1'b0, si_q};
	assign col = EW'(bx_q) + EW'(c_q);
	assign row = EW'(by_q) + EW'(r_q);
	// zero image size shades as if it were one
	assign wd = (img_w_q == '0) ? EW'(1) : img_w_q;
	assign hd = (img_h_q == '0) ? EW'(1) : img_h_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = {blue_q, red_q, row[mbs_pkg::COORD_BITS-1:0],
		col[mbs_pkg::COORD_BITS-1:0]};
	assign m_axis_tlast  = last_q;

	// configuration writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q  <= EW'(640);
			img_h_q  <= EW'(480);
			scale_q  <= 63'd281474976710656;
			foc_re_q <= '0;
			foc_im_q <= '0;
			blk_w_q  <= BW'(8);
			blk_h_q  <= BW'(8);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mbs_pkg::CFG_IMAGE_WIDTH:  img_w_q  <= cfg_data[EW-1:0];
				mbs_pkg::CFG_IMAGE_HEIGHT: img_h_q  <= cfg_data[EW-1:0];
				mbs_pkg::CFG_PIXEL_SCALE:  scale_q  <= cfg_data[62:0];
				mbs_pkg::CFG_FOCUS_REAL:   foc_re_q <= cfg_data;
				mbs_pkg::CFG_FOCUS_IMAG:   foc_im_q <= cfg_data;
				mbs_pkg::CFG_BLOCK_WIDTH:  blk_w_q  <= cfg_data[BW-1:0];
				mbs_pkg::CFG_BLOCK_HEIGHT: blk_h_q  <= cfg_data[BW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mul_req.start <= 1'b0;
			div_req.start <= 1'b0;
			c_q           <= '0;
			r_q           <= '0;
			step_q        <= '0;
			k_q           <= '0;
			last_q        <= 1'b0;
		end else begin
			mul_req.start <= 1'b0;
			div_req.start <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						bx_q    <= s_axis_tdata[11:0];
						by_q    <= s_axis_tdata[23:12];
						rr_q    <= s_axis_tdata[36:24];
						rb_q    <= s_axis_tdata[49:37];
						bw_q    <= bw_c;
						bh_q    <= bh_c;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					ncols_q <= span(rr_q, bx_q, bw_q);
					nrows_q <= span(rb_q, by_q, bh_q);
					c_q     <= '0;
					r_q     <= '0;
					if (span(rr_q, bx_q, bw_q) == '0 || span(rb_q, by_q, bh_q) == '0) begin
						state_q <= S_IDLE;
					end else begin
						dre_neg_q     <= d_re[14];
						dim_neg_q     <= d_im[14];
						m_im_q        <= m_im;
						mul_req.start <= 1'b1;
						mul_req.a     <= {1'b0, scale_q};
						mul_req.b     <= {50'd0, m_re};
						state_q       <= S_MAPR;
					end
				end
				S_MAPR: begin
					if (mul_rsp.done) begin
						cr_q          <= map_c(mul_rsp.prod, dre_neg_q, foc_re_q);
						mul_req.start <= 1'b1;
						mul_req.a     <= {1'b0, scale_q};
						mul_req.b     <= {50'd0, m_im_q};
						state_q       <= S_MAPI;
					end
				end
				S_MAPI: begin
					if (mul_rsp.done) begin
						ci_q    <= map_c(mul_rsp.prod, dim_neg_q, foc_im_q);
						zr_q    <= '0;
						zi_q    <= '0;
						step_q  <= '0;
						k_q     <= '0;
						state_q <= S_ESC;
					end
				end
				S_ESC: begin
					// a component already at 2 escapes before any squaring
					if (ar_c >= TWO || ai_c >= TWO) begin
						shade_q <= mbs_pkg::shade_of_k(k_q);
						state_q <= S_PIX;
					end else begin
						ar_q          <= ar_c;
						ai_q          <= ai_c;
						mul_req.start <= 1'b1;
						mul_req.a     <= ar_c;
						mul_req.b     <= ar_c;
						state_q       <= S_SQR;
					end
				end
				S_SQR: begin
					if (mul_rsp.done) begin
						sr_q          <= sq_shf;
						mul_req.start <= 1'b1;
						mul_req.a     <= ai_q;
						mul_req.b     <= ai_q;
						state_q       <= S_SQI;
					end
				end
				S_SQI: begin
					if (mul_rsp.done) begin
						si_q          <= sq_shf;
						mul_req.start <= 1'b1;
						mul_req.a     <= ar_q;
						mul_req.b     <= ai_q;
						state_q       <= S_CROSS;
					end
				end
				S_CROSS: begin
					if (mul_rsp.done) begin
						if (mag2 >= FOUR) begin
							shade_q <= mbs_pkg::shade_of_k(k_q);
							state_q <= S_PIX;
						end else if (step_q == SW'(MAX_ITER)) begin
							// never escaped
							shade_q <= 8'd0;
							state_q <= S_PIX;
						end else begin
							zr_q   <= mbs_pkg::sat_add(sr_q - si_q, cr_q);
							zi_q   <= mbs_pkg::sat_add((zr_q[63] ^ zi_q[63]) ?
								(64'd0 - cross_p) : cross_p, ci_q);
							step_q <= step_q + SW'(1);
							k_q    <= (k_q == 6'd50) ? 6'd0 : k_q + 6'd1;
							state_q <= S_ESC;
						end
					end
				end
				S_PIX: begin
					div_req.start <= 1'b1;
					div_req.num   <= {13'd0, shade_q} * {8'd0, col};
					div_req.den   <= wd;
					state_q       <= S_DIVR;
				end
				S_DIVR: begin
					if (div_rsp.done) begin
						red_q         <= div_rsp.quo;
						div_req.start <= 1'b1;
						div_req.num   <= {13'd0, shade_q} * {8'd0, row};
						div_req.den   <= hd;
						state_q       <= S_DIVB;
					end
				end
				S_DIVB: begin
					if (div_rsp.done) begin
						blue_q  <= div_rsp.quo;
						last_q  <= (c_q == ncols_q - BW'(1)) && (r_q == nrows_q - BW'(1));
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_axis_tready) begin
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							if (c_q == ncols_q - BW'(1)) begin
								c_q <= '0;
								r_q <= r_q + BW'(1);
							end else begin
								c_q <= c_q + BW'(1);
							end
							state_q <= S_PIX;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a new product or quotient is never requested while one is in flight
	`MBS_NEVER(a_mul_overlap, mul_req.start && mul_rsp.busy)
	`MBS_NEVER(a_div_overlap, div_req.start && div_rsp.busy)
	// one block at a time: no pixel pending while a block is taken
	`MBS_NEVER(a_in_out_excl, s_axis_tready && m_axis_tvalid)
	// the last pixel of a block frees the input side
	`MBS_ASSERT(a_last_frees, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)

endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;

	// register index outside the map, the block must ignore it
	localparam logic [2:0] CFG_UNMAPPED = 3'd7;
	// settle time after the last pixel before touching registers or ending
	localparam int SETTLE_CYCLES = 2600;

	typedef enum logic [1:0] {REQ_BLOCK, REQ_CFG, REQ_DRAIN} req_kind_e;

	typedef struct {
		req_kind_e   kind;
		logic [63:0] data;
		logic [2:0]  index;
	} pending_req_t;

	typedef struct packed {
		logic        last;
		logic [7:0]  blue;
		logic [7:0]  red;
		logic [11:0] y;
		logic [11:0] x;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	mandelbrot_block_shader dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// shadow copy of the register file
	logic [12:0]        img_w = 13'd640;
	logic [12:0]        img_h = 13'd480;
	logic [62:0]        step_scale = 63'd281474976710656;
	logic signed [63:0] center_re = '0;
	logic signed [63:0] center_im = '0;
	logic [3:0]         tile_w = 4'd8;
	logic [3:0]         tile_h = 4'd8;

	pending_req_t pending_q[$];
	pixel_t       pixels_due[$];
	int           errors = 0;
	int           blocks_sent = 0;
	int           pixels_seen = 0;
	bit           drive_busy = 1'b0;

	// signed add clamped to the 64 bit range
	function automatic logic signed [63:0] clamp_add(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic [63:0] abs64(logic [63:0] v);
		return v[63] ? 64'd0 - v : v;
	endfunction

	// full 128 bit product, shifted right, low 64 bits kept
	function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> sh);
	endfunction

	// map a pixel position to the complex plane, rounding the offset toward zero
	function automatic logic signed [63:0] plane_coord(longint centre, longint size,
			logic signed [63:0] focus);
		longint       d;
		logic [63:0]  m;
		logic [127:0] p;
		logic [63:0]  half;
		d = 2 * centre - size;
		m = d < 0 ? 64'(-d) : 64'(d);
		p = {65'd0, step_scale} * {64'd0, m};
		if (p[127:64] != 0)
			return d > 0 ? {1'b0, {63{1'b1}}} : {1'b1, 63'd0};
		half = p[64:1];
		return clamp_add(focus, d < 0 ? -$signed(half) : $signed(half));
	endfunction

	function automatic int escape_shade(logic signed [63:0] cr, logic signed [63:0] ci);
		logic [63:0]        two, four, ar, ai, sr, si, p;
		logic signed [63:0] zr, zi, pi;
		bit                 esc;
		int                 step;
		two = 64'd2 << 56;
		four = 64'd4 << 56;
		zr = '0;
		zi = '0;
		step = 0;
		forever begin
			ar = abs64(zr);
			ai = abs64(zi);
			sr = '0;
			si = '0;
			esc = ar >= two || ai >= two;
			if (!esc) begin
				sr = mul_shr(ar, ar, 56);
				si = mul_shr(ai, ai, 56);
				esc = sr + si >= four;
			end
			if (esc)
				return (step % 51) * 255 / 50;
			if (step >= 100)
				return 0;
			p = mul_shr(ar, ai, 55);
			// sign of the cross term from the old z
			pi = (zr[63] != zi[63]) ? -$signed(p) : $signed(p);
			zr = clamp_add($signed(sr) - $signed(si), cr);
			zi = clamp_add(pi, ci);
			step++;
		end
	endfunction

	// queue every pixel one block request should produce
	task automatic shade_block(logic [55:0] req);
		int bx, by, rr, rb, bw, bh, ncols, nrows, shade, wd, hd, col, row, n;
		longint rv, bv;
		pixel_t px;
		bx = req[11:0];
		by = req[23:12];
		rr = req[36:24];
		rb = req[49:37];
		bw = tile_w == 0 ? 1 : (tile_w > 8 ? 8 : tile_w);
		bh = tile_h == 0 ? 1 : (tile_h > 8 ? 8 : tile_h);
		ncols = rr > bx ? rr - bx : 0;
		if (ncols > bw) ncols = bw;
		nrows = rb > by ? rb - by : 0;
		if (nrows > bh) nrows = bh;
		if (ncols == 0 || nrows == 0)
			return;
		shade = escape_shade(plane_coord(bx + bw / 2, img_w, center_re),
			plane_coord(by + bh / 2, img_h, center_im));
		wd = img_w == 0 ? 1 : img_w;
		hd = img_h == 0 ? 1 : img_h;
		n = 0;
		for (int r = 0; r < nrows; r++)
			for (int c = 0; c < ncols; c++) begin
				col = bx + c;
				row = by + r;
				rv = longint'(shade) * col / wd;
				bv = longint'(shade) * row / hd;
				n++;
				px.x = col[11:0];
				px.y = row[11:0];
				px.red = rv > 255 ? 8'd255 : rv[7:0];
				px.blue = bv > 255 ? 8'd255 : bv[7:0];
				px.last = n == ncols * nrows;
				pixels_due.push_back(px);
			end
	endtask

	// driver: one request in flight at a time, random gaps between requests
	always @(posedge clk or negedge arst_n) begin
		int            gap;
		int            hold;
		logic          nxt_s, nxt_c;
		pending_req_t  head;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
			drive_busy = 1'b0;
			gap = 0;
			hold = 0;
			img_w = 13'd640;
			img_h = 13'd480;
			step_scale = 63'd281474976710656;
			center_re = '0;
			center_im = '0;
			tile_w = 4'd8;
			tile_h = 4'd8;
		end else begin
			nxt_s = s_axis_tvalid;
			nxt_c = cfg_valid;
			if (s_axis_tvalid && s_axis_tready) begin
				shade_block(s_axis_tdata);
				nxt_s = 1'b0;
				drive_busy = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mbs_pkg::CFG_IMAGE_WIDTH:  img_w = cfg_data[12:0];
					mbs_pkg::CFG_IMAGE_HEIGHT: img_h = cfg_data[12:0];
					mbs_pkg::CFG_PIXEL_SCALE:  step_scale = cfg_data[62:0];
					mbs_pkg::CFG_FOCUS_REAL:   center_re = cfg_data;
					mbs_pkg::CFG_FOCUS_IMAG:   center_im = cfg_data;
					mbs_pkg::CFG_BLOCK_WIDTH:  tile_w = cfg_data[3:0];
					mbs_pkg::CFG_BLOCK_HEIGHT: tile_h = cfg_data[3:0];
					default: ;
				endcase
				nxt_c = 1'b0;
				drive_busy = 1'b0;
			end
			if (!drive_busy && pending_q.size() > 0) begin
				head = pending_q[0];
				if (gap > 0) begin
					gap--;
				end else if (head.kind == REQ_DRAIN) begin
					// idle until nothing is owed, then let a silent block finish
					if (pixels_due.size() == 0) begin
						hold++;
						if (hold >= SETTLE_CYCLES) begin
							hold = 0;
							void'(pending_q.pop_front());
						end
					end
				end else begin
					void'(pending_q.pop_front());
					drive_busy = 1'b1;
					if (head.kind == REQ_BLOCK) begin
						nxt_s = 1'b1;
						s_axis_tdata <= head.data[55:0];
						blocks_sent++;
					end else begin
						nxt_c = 1'b1;
						cfg_index <= head.index;
						cfg_data <= head.data;
					end
					// every so often a run of back-to-back requests
					gap = (blocks_sent % 64) >= 48 ? 0 : $urandom_range(0, 4);
				end
			end
			s_axis_tvalid <= nxt_s;
			cfg_valid <= nxt_c;
		end
	end

	// monitor: random backpressure, compare against the oldest owed pixel
	always @(posedge clk or negedge arst_n) begin
		int     stall;
		pixel_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tlast, m_axis_tdata[39:32], m_axis_tdata[31:24],
					m_axis_tdata[23:12], m_axis_tdata[11:0]};
				pixels_seen++;
				if (pixels_due.size() == 0) begin
					$display("%0t: unexpected pixel x=%0d y=%0d r=%0d b=%0d last=%0b",
						$time, got.x, got.y, got.red, got.blue, got.last);
					errors++;
				end else begin
					want = pixels_due.pop_front();
					if (got !== want) begin
						$display("%0t: pixel mismatch expected x=%0d y=%0d r=%0d b=%0d last=%0b",
							$time, want.x, want.y, want.red, want.blue, want.last);
						$display("%0t:                actual   x=%0d y=%0d r=%0d b=%0d last=%0b",
							$time, got.x, got.y, got.red, got.blue, got.last);
						errors++;
					end
				end
				stall = (pixels_seen % 200) >= 150 ? 0 : $urandom_range(0, 4);
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic add_block(int bx, int by, int rr, int rb);
		pending_req_t r;
		r.kind = REQ_BLOCK;
		r.index = '0;
		r.data = {14'd0, 13'(rb), 13'(rr), 12'(by), 12'(bx)};
		pending_q.push_back(r);
	endtask

	task automatic add_drain();
		pending_req_t r;
		r.kind = REQ_DRAIN;
		r.index = '0;
		r.data = '0;
		pending_q.push_back(r);
	endtask

	// register writes always follow a full drain
	task automatic add_cfg(logic [2:0] idx, logic [63:0] val);
		pending_req_t r;
		r.kind = REQ_CFG;
		r.index = idx;
		r.data = val;
		pending_q.push_back(r);
	endtask

	initial begin
		int          w, h, bx, by, rr, rb;
		logic [63:0] v;
		// reset configuration: corner, centre of the set, bottom edge, clipping
		add_block(0, 0, 4096, 4096);
		add_block(316, 236, 4096, 4096);
		add_block(4088, 4088, 4096, 4096);
		add_block(4095, 4095, 4096, 4096);
		add_block(100, 100, 100, 4096);
		add_block(100, 100, 4096, 100);
		add_block(100, 100, 103, 102);
		add_block(0, 0, 1, 1);
		// smallest image, zero step, most negative focus
		add_drain();
		add_cfg(mbs_pkg::CFG_IMAGE_WIDTH, 64'd1);
		add_cfg(mbs_pkg::CFG_IMAGE_HEIGHT, 64'd1);
		add_cfg(mbs_pkg::CFG_PIXEL_SCALE, 64'd0);
		add_cfg(mbs_pkg::CFG_FOCUS_REAL, 64'h8000_0000_0000_0000);
		add_block(0, 0, 8, 8);
		add_block(7, 3, 4096, 4096);
		// step at its maximum saturates the mapped point, imaginary focus at its maximum
		add_drain();
		add_cfg(mbs_pkg::CFG_PIXEL_SCALE, 64'hFFFF_FFFF_FFFF_FFFF);
		add_cfg(mbs_pkg::CFG_FOCUS_REAL, 64'h0);
		add_cfg(mbs_pkg::CFG_FOCUS_IMAG, 64'h7FFF_FFFF_FFFF_FFFF);
		add_cfg(mbs_pkg::CFG_BLOCK_WIDTH, 64'd0);
		add_cfg(mbs_pkg::CFG_BLOCK_HEIGHT, 64'd15);
		add_block(0, 0, 4096, 4096);
		add_block(4095, 0, 4096, 4096);
		// zero image size, widest image, unmapped index
		add_drain();
		add_cfg(mbs_pkg::CFG_IMAGE_WIDTH, 64'd0);
		add_cfg(mbs_pkg::CFG_IMAGE_HEIGHT, 64'd0);
		add_cfg(mbs_pkg::CFG_PIXEL_SCALE, 64'd1 << 48);
		add_cfg(mbs_pkg::CFG_FOCUS_REAL, 64'hFF80_0000_0000_0000);
		add_cfg(mbs_pkg::CFG_BLOCK_WIDTH, 64'd8);
		add_cfg(mbs_pkg::CFG_BLOCK_HEIGHT, 64'd3);
		add_cfg(CFG_UNMAPPED, 64'hFF00_0000_0000_0005);
		add_block(0, 0, 4096, 4096);
		add_block(12, 40, 16, 42);
		add_drain();
		add_cfg(mbs_pkg::CFG_IMAGE_WIDTH, 64'h1000);
		add_cfg(mbs_pkg::CFG_IMAGE_HEIGHT, 64'h1FFF);
		add_cfg(mbs_pkg::CFG_PIXEL_SCALE, 64'd1 << 45);
		add_cfg(mbs_pkg::CFG_FOCUS_REAL, 64'h0);
		add_cfg(mbs_pkg::CFG_FOCUS_IMAG, 64'h0);
		add_block(2044, 2044, 4096, 4096);
		add_block(4090, 4093, 4096, 4096);
		add_block(0, 4095, 4096, 4096);

		// random phases, each under a fresh configuration
		for (int ph = 0; ph < 6; ph++) begin
			add_drain();
			w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
			h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
			add_cfg(mbs_pkg::CFG_IMAGE_WIDTH, 64'(w));
			add_cfg(mbs_pkg::CFG_IMAGE_HEIGHT, 64'(h));
			v = (64'd1 << $urandom_range(36, 50)) + 64'($urandom);
			if ($urandom_range(0, 5) == 0) v = {$urandom, $urandom};
			add_cfg(mbs_pkg::CFG_PIXEL_SCALE, v);
			v = -(64'd1 << 55) + {{16{1'b0}}, 16'($urandom), $urandom};
			if ($urandom_range(0, 5) == 0) v = {$urandom, $urandom};
			add_cfg(mbs_pkg::CFG_FOCUS_REAL, v);
			v = 64'($signed($urandom)) <<< 20;
			add_cfg(mbs_pkg::CFG_FOCUS_IMAG, v);
			add_cfg(mbs_pkg::CFG_BLOCK_WIDTH, 64'($urandom_range(0, 15)));
			add_cfg(mbs_pkg::CFG_BLOCK_HEIGHT, 64'($urandom_range(0, 15)));
			for (int i = 0; i < 44; i++) begin
				if (i == 22) add_drain();
				if ($urandom_range(0, 9) < 7 && w > 0 && h > 0) begin
					// block in the image, region covering or clipping it
					bx = $urandom_range(0, (w > 4096 ? 4096 : w) - 1);
					by = $urandom_range(0, (h > 4096 ? 4096 : h) - 1);
					rr = bx + $urandom_range(1, 12);
					rb = by + $urandom_range(1, 12);
				end else begin
					bx = $urandom_range(0, 4095);
					by = $urandom_range(0, 4095);
					rr = $urandom_range(1, 4096);
					rb = $urandom_range(1, 4096);
				end
				add_block(bx, by, rr > 4096 ? 4096 : rr, rb > 4096 ? 4096 : rb);
			end
		end

		forever begin
			@(posedge clk);
			if (pending_q.size() == 0 && !drive_busy && pixels_due.size() == 0)
				break;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("** mandelbrot_block_shader: PASSED **");
		else
			$display("** mandelbrot_block_shader: FAILED **");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("** mandelbrot_block_shader: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
